// ===== sv/ule_pkg.sv =====
// shared types and codes for the unsorted list engine
// operation and status codes, control bundle from the top level to the cells
// no dependencies
package ule_pkg;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_RETRIEVE = 3'd2,
        OP_RESET    = 3'd3,
        OP_NEXT     = 3'd4,
        OP_EMPTY    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

// ===== sv/unsorted_list_engine_top.sv =====
// top level of the unsorted list engine: handshakes, count, cursor, result register
// instantiates a row of ule_cell, uses ule_pkg
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_operation s_value
//   m_      | out       | m_valid m_ready m_status m_found m_item_out m_length m_full_res
//
// each word is captured into the operation and value registers in S_IDLE; in S_EXEC the row
// of cells compares, chains the first hit and shifts, which also loads the result register
// the next word is taken while a result still waits on m_ready
// a waiting result holds the execute state until m_ready frees the register
// aresetn is synchronous; it clears count, cursor and handshake state, not the cells
module unsorted_list_engine_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [31:0] m_item_out,
    output logic [4:0]  m_length,
    output logic        m_full_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            status_reg, status_next;
    logic                  found_reg, found_next;
    logic [31:0]           item_reg, item_next;
    logic [CNT_W-1:0]      len_reg, len_next;

    logic                  exec;
    logic                  not_full;
    logic                  found_any;
    ule_pkg::cell_ctrl_t   ctrl;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] left_in   [CAPACITY];
    logic [DATA_WIDTH-1:0] right_in  [CAPACITY];
    logic [CAPACITY:0]     hit;

    assign s_ready   = (state_reg == S_IDLE);
    assign exec      = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign not_full  = (count_reg < CNT_W'(CAPACITY));
    assign found_any = hit[CAPACITY];
    assign hit[0]    = 1'b0;

    assign ctrl.ins = exec && (op_reg == ule_pkg::OP_INSERT) && not_full;
    assign ctrl.del = exec && (op_reg == ule_pkg::OP_DELETE);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign left_in[gi] = val_reg;
            end else begin : g_body
                assign left_in[gi] = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign right_in[gi] = cell_data[gi];
            end else begin : g_inner
                assign right_in[gi] = cell_data[gi+1];
            end

            ule_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .value      (val_reg),
                .left_data  (left_in[gi]),
                .right_data (right_in[gi]),
                .live       (count_reg > CNT_W'(gi)),
                .hit_in     (hit[gi]),
                .data       (cell_data[gi]),
                .hit_out    (hit[gi+1])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        item_next    = item_reg;
        len_next     = len_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (state_reg == S_IDLE) begin
            if (s_valid) begin
                op_next    = s_operation;
                val_next   = DATA_WIDTH'(s_value);
                state_next = S_EXEC;
            end
        end else if (exec) begin
            state_next   = S_IDLE;
            m_valid_next = 1'b1;
            status_next  = ule_pkg::ST_OK;
            found_next   = 1'b0;
            item_next    = '0;
            unique case (op_reg)
                ule_pkg::OP_INSERT: begin
                    cursor_next = '0;
                    if (not_full) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        status_next = ule_pkg::ST_FULL;
                    end
                end
                ule_pkg::OP_DELETE: begin
                    cursor_next = '0;
                    if (found_any) begin
                        found_next = 1'b1;
                        count_next = count_reg - 1'b1;
                    end else begin
                        status_next = ule_pkg::ST_NOT_FOUND;
                    end
                end
                ule_pkg::OP_RETRIEVE: begin
                    found_next = found_any;
                end
                ule_pkg::OP_RESET: begin
                    cursor_next = '0;
                end
                ule_pkg::OP_NEXT: begin
                    if (cursor_reg < count_reg) begin
                        item_next   = 32'(cell_data[cursor_reg[IDX_W-1:0]]);
                        cursor_next = cursor_reg + 1'b1;
                    end else begin
                        status_next = ule_pkg::ST_END;
                    end
                end
                ule_pkg::OP_EMPTY: begin
                    count_next  = '0;
                    cursor_next = '0;
                end
                default: begin
                end
            endcase
            len_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        item_reg   <= item_next;
        len_reg    <= len_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_found    = found_reg;
    assign m_item_out = item_reg;
    assign m_length   = 5'(len_reg);
    assign m_full_res = (len_reg == CNT_W'(CAPACITY));

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= count_reg)
        else $error("cursor beyond last entry");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC) && !s_ready)
        else $error("accepted word did not enter execute");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> (count_reg == $past(count_reg) + 1'b1) && m_valid)
        else $error("insert did not grow the list");

    a_result_len: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> (len_reg == count_reg))
        else $error("reported length differs from count");

endmodule

// ===== sv/ule_cell.sv =====
// one list cell: holds a single entry, compares it with the search value
// and shifts toward the tail on insert or toward the head on delete
// depends on ule_pkg
module ule_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  ule_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]  value,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic                   live,
    input  logic                   hit_in,
    output logic [DATA_WIDTH-1:0]  data,
    output logic                   hit_out
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  match;

    assign match   = live && (data_reg == value);
    assign hit_out = hit_in | match;
    assign data    = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            data_next = left_data;
        end else if (ctrl.del && hit_out) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== verif/unsorted_list_engine_top_tb.sv =====
// self-checking testbench for unsorted_list_engine_top: drives operation words, predicts each
// result from a local copy of the list, count and cursor, and compares every result word
// depends on ule_pkg and unsorted_list_engine_top
`timescale 1ns / 1ps

module unsorted_list_engine_top_tb;

    localparam int LIST_DEPTH  = 16;
    localparam int WORD_TARGET = 1525;
    localparam int CALM_TAIL   = 200;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] val;
    } list_word_t;

    typedef struct packed {
        ule_pkg::status_t status;
        logic             found;
        logic [31:0]      item;
        logic [4:0]       length;
        logic             full;
    } list_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = '0;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_found;
    logic [31:0] m_item_out;
    logic [4:0]  m_length;
    logic        m_full_res;

    list_word_t   pending_words[$];
    list_result_t pending_results[$];

    logic [31:0] list_slots [0:LIST_DEPTH-1];
    int          list_count = 0;
    int          list_cursor = 0;
    logic [31:0] value_pool [0:7];

    int mismatches = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int src_gap = 0;
    int sink_hold = 0;

    unsorted_list_engine_top #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_found    (m_found),
        .m_item_out (m_item_out),
        .m_length   (m_length),
        .m_full_res (m_full_res)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic list_result_t apply_list_op(logic [2:0] op, logic [31:0] val);
        list_result_t res;
        int i;
        int hit;
        res = '0;
        res.status = ule_pkg::ST_OK;
        hit = list_count;
        for (i = list_count - 1; i >= 0; i--) begin
            if (list_slots[i] == val) hit = i;
        end
        case (op)
            ule_pkg::OP_INSERT: begin
                list_cursor = 0;
                if (list_count >= LIST_DEPTH) begin
                    res.status = ule_pkg::ST_FULL;
                end else begin
                    for (i = list_count; i > 0; i--) list_slots[i] = list_slots[i-1];
                    list_slots[0] = val;
                    list_count++;
                end
            end
            ule_pkg::OP_DELETE: begin
                list_cursor = 0;
                if (hit < list_count) begin
                    res.found = 1'b1;
                    for (i = hit; i + 1 < list_count; i++) list_slots[i] = list_slots[i+1];
                    list_count--;
                end else begin
                    res.status = ule_pkg::ST_NOT_FOUND;
                end
            end
            ule_pkg::OP_RETRIEVE: res.found = (hit < list_count);
            ule_pkg::OP_RESET: list_cursor = 0;
            ule_pkg::OP_NEXT: begin
                if (list_cursor < list_count) begin
                    res.item = list_slots[list_cursor];
                    list_cursor++;
                end else begin
                    res.status = ule_pkg::ST_END;
                end
            end
            ule_pkg::OP_EMPTY: begin
                list_count = 0;
                list_cursor = 0;
            end
            default: ;
        endcase
        res.length = list_count[4:0];
        res.full = (list_count >= LIST_DEPTH);
        return res;
    endfunction

    task automatic queue_word(input logic [2:0] op, input logic [31:0] val);
        pending_words.push_back('{op: op, val: val});
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 4) < 3) return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // driver
    always @(posedge aclk) begin
        list_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) pending_results.push_back(apply_list_op(s_operation, s_value));
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_operation <= w.op;
                s_value <= w.val;
                if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 7);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $write("unexpected result word: ");
                        $display("st=%0d found=%0d item=%h len=%0d full=%0d",
                                 m_status, m_found, m_item_out, m_length, m_full_res);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status || m_found !== want.found ||
                        m_item_out !== want.item || m_length !== want.length ||
                        m_full_res !== want.full) begin
                        if (mismatches < 10) begin
                            $write("mismatch on result %0d: ", results_seen);
                            $write("exp st=%0d found=%0d item=%h len=%0d full=%0d, ",
                                   want.status, want.found, want.item,
                                   want.length, want.full);
                            $display("got st=%0d found=%0d item=%h len=%0d full=%0d",
                                     m_status, m_found, m_item_out,
                                     m_length, m_full_res);
                        end
                        mismatches++;
                    end
                end
                if (results_seen == 300 || results_seen == 1000) sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
                sink_hold = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int scen;
        int n;
        int j;
        logic [31:0] held [0:17];
        logic [31:0] tmp;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) value_pool[i] = $urandom();

        // empty list corners, unused codes, duplicates, cursor walk past the end
        queue_word(ule_pkg::OP_NEXT, 32'h0);
        queue_word(ule_pkg::OP_DELETE, 32'h0);
        queue_word(ule_pkg::OP_RETRIEVE, 32'h0);
        queue_word(OP_SPARE_A, 32'hFFFF_FFFF);
        queue_word(OP_SPARE_B, 32'h0);
        queue_word(ule_pkg::OP_INSERT, 32'h0);
        queue_word(ule_pkg::OP_INSERT, 32'hFFFF_FFFF);
        queue_word(ule_pkg::OP_INSERT, 32'h5);
        queue_word(ule_pkg::OP_INSERT, 32'h5);
        queue_word(ule_pkg::OP_RETRIEVE, 32'hFFFF_FFFF);
        queue_word(ule_pkg::OP_RETRIEVE, 32'h7);
        queue_word(ule_pkg::OP_NEXT, 32'h0);
        queue_word(ule_pkg::OP_NEXT, 32'h0);
        queue_word(ule_pkg::OP_RESET, 32'h0);
        queue_word(ule_pkg::OP_NEXT, 32'h0);
        queue_word(ule_pkg::OP_DELETE, 32'h5);
        queue_word(ule_pkg::OP_DELETE, 32'h9);
        for (int i = 0; i < 5; i++) queue_word(ule_pkg::OP_NEXT, 32'hFFFF_FFFF);
        queue_word(ule_pkg::OP_INSERT, 32'h8000_0000);
        queue_word(ule_pkg::OP_NEXT, 32'h0);
        queue_word(ule_pkg::OP_EMPTY, 32'h0);

        while (pending_words.size() < WORD_TARGET) begin
            scen = $urandom_range(0, 9);
            case (scen)
                0, 1, 2: begin
                    n = $urandom_range(1, 20);
                    for (int i = 0; i < n; i++) queue_word(ule_pkg::OP_INSERT, pick_value());
                end
                3, 4: begin
                    queue_word(ule_pkg::OP_RESET, $urandom());
                    n = $urandom_range(1, 18);
                    for (int i = 0; i < n; i++) queue_word(ule_pkg::OP_NEXT, $urandom());
                end
                5, 6: begin
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        queue_word($urandom_range(0, 1) ? ule_pkg::OP_DELETE
                                                        : ule_pkg::OP_RETRIEVE,
                                   pick_value());
                end
                7: begin
                    queue_word(ule_pkg::OP_EMPTY, $urandom());
                    n = $urandom_range(14, 18);
                    for (int i = 0; i < n; i++) begin
                        held[i] = pick_value();
                        queue_word(ule_pkg::OP_INSERT, held[i]);
                    end
                    for (int i = 0; i <= LIST_DEPTH; i++) queue_word(ule_pkg::OP_NEXT, $urandom());
                    for (int i = n - 1; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        tmp = held[i];
                        held[i] = held[j];
                        held[j] = tmp;
                    end
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 3) == 0) queue_word(ule_pkg::OP_RETRIEVE, held[i]);
                        queue_word(ule_pkg::OP_DELETE, held[i]);
                    end
                end
                8: begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) queue_word(3'($urandom_range(0, 7)), $urandom());
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) queue_word(ule_pkg::OP_EMPTY, $urandom());
                    else queue_word(3'($urandom_range(0, 4)), pick_value());
                end
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ule_pkg.sv
sv/ule_cell.sv
sv/unsorted_list_engine_top.sv
verif/unsorted_list_engine_top_tb.sv
